@@ sv/segment_segment_distance_3d_unit_assert.svh @@
// Assertion macros for the segment distance unit.
// Used by the top level; expects clk and arst_n in scope.
`ifndef SEGMENT_SEGMENT_DISTANCE_3D_UNIT_ASSERT_SVH
`define SEGMENT_SEGMENT_DISTANCE_3D_UNIT_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define SSD_ASSERT_IMPLY(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("ssd: implication check failed");
`define SSD_ASSERT_NEVER(label, cond) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) \
		else $error("ssd: forbidden condition seen");
`else
`define SSD_ASSERT_IMPLY(label, ante, cons)
`define SSD_ASSERT_NEVER(label, cond)
`endif
`endif

@@ sv/ssd_pkg.sv @@
// Shared types, widths and helpers for the segment distance unit.
// No dependencies.
`timescale 1ns / 1ps

package ssd_pkg;

	localparam int COORD_W     = 16;
	localparam int DIFF_W      = COORD_W + 1;
	localparam int PROD_W      = 2 * DIFF_W;
	localparam int DOT_W       = PROD_W + 4;
	localparam int WIDE_W      = 2 * DOT_W - 4;
	localparam int PARAM_FRAC  = 16;
	localparam int PARAM_W     = 17;
	localparam int DIV_STEPS   = PARAM_FRAC + 1;
	localparam int DF_W        = 36;
	localparam int SQ_W        = 72;
	localparam int ROOT_W      = SQ_W / 2;
	localparam int REM_W       = ROOT_W + 3;
	localparam int DIST_SHIFT  = PARAM_FRAC - 8;
	localparam int RND_W       = ROOT_W - DIST_SHIFT;
	localparam int DIST_W      = 25;
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

	typedef logic signed [COORD_W-1:0] coord_t;
	typedef logic signed [DIFF_W-1:0]  diff_t;
	typedef logic signed [PROD_W-1:0]  prod_t;
	typedef logic signed [DOT_W-1:0]   dot_t;
	typedef logic signed [WIDE_W-1:0]  wide_t;
	typedef logic signed [DF_W-1:0]    df_t;
	typedef logic [PARAM_W-1:0]        param_t;
	typedef logic [DIST_W-1:0]         dist_t;

	localparam dot_t   DOT_ZERO  = '0;
	localparam wide_t  WIDE_ZERO = '0;
	localparam param_t PARAM_ONE = param_t'(1 << PARAM_FRAC);
	localparam dist_t  DIST_MAX  = '1;

	typedef enum logic [1:0] {
		PM_ZERO,
		PM_ONE,
		PM_DIV
	} pmode_t;

	// one parameter: forced to zero or one, or num/den with 0 < num < den
	typedef struct packed {
		pmode_t            mode;
		logic [WIDE_W-1:0] num;
		logic [WIDE_W-1:0] den;
	} pjob_t;

	typedef struct packed {
		diff_t [2:0] d1;
		diff_t [2:0] d2;
		diff_t [2:0] r0;
	} geo_t;

	typedef struct packed {
		pjob_t s_job;
		pjob_t t_job;
		geo_t  geo;
	} work_t;

	typedef struct packed {
		logic full;
		logic empty;
	} qstat_t;

	function automatic diff_t sub_coord(coord_t a, coord_t b);
		return diff_t'(a) - diff_t'(b);
	endfunction

	function automatic pjob_t mk_job(pmode_t m, wide_t n, wide_t d);
		pjob_t j;
		j.mode = m;
		j.num  = n;
		j.den  = d;
		return j;
	endfunction

	function automatic pjob_t clamp_job(logic le0, logic ge, dot_t n, dot_t d);
		pmode_t m;
		if (le0) begin
			m = PM_ZERO;
		end else if (ge) begin
			m = PM_ONE;
		end else begin
			m = PM_DIV;
		end
		return mk_job(m, wide_t'(n), wide_t'(d));
	endfunction

endpackage

@@ sv/ssd_in_if.sv @@
// Request channel carrying the two segments' end points.
// Depends on ssd_pkg.
`timescale 1ns / 1ps

interface ssd_in_if;
	logic valid;
	logic ready;
	ssd_pkg::coord_t first_start_x;
	ssd_pkg::coord_t first_start_y;
	ssd_pkg::coord_t first_start_z;
	ssd_pkg::coord_t first_end_x;
	ssd_pkg::coord_t first_end_y;
	ssd_pkg::coord_t first_end_z;
	ssd_pkg::coord_t second_start_x;
	ssd_pkg::coord_t second_start_y;
	ssd_pkg::coord_t second_start_z;
	ssd_pkg::coord_t second_end_x;
	ssd_pkg::coord_t second_end_y;
	ssd_pkg::coord_t second_end_z;

	modport source (
		output valid, first_start_x, first_start_y, first_start_z,
		output first_end_x, first_end_y, first_end_z,
		output second_start_x, second_start_y, second_start_z,
		output second_end_x, second_end_y, second_end_z,
		input  ready
	);
	modport sink (
		input  valid, first_start_x, first_start_y, first_start_z,
		input  first_end_x, first_end_y, first_end_z,
		input  second_start_x, second_start_y, second_start_z,
		input  second_end_x, second_end_y, second_end_z,
		output ready
	);
endinterface

@@ sv/ssd_out_if.sv @@
// Result channel: distance and the two closest-point parameters.
// Depends on ssd_pkg.
`timescale 1ns / 1ps

interface ssd_out_if;
	logic valid;
	logic ready;
	ssd_pkg::dist_t  distance;
	ssd_pkg::param_t param_first;
	ssd_pkg::param_t param_second;

	modport source (output valid, distance, param_first, param_second, input ready);
	modport sink (input valid, distance, param_first, param_second, output ready);
endinterface

@@ sv/ssd_front.sv @@
// Front end: differences, dot products, determinant and region pick.
// Seven stages; emits one parameter job pair per request. Depends on ssd_pkg.
`timescale 1ns / 1ps

module ssd_front (
	input  logic           clk,
	input  logic           arst_n,
	ssd_in_if.sink         pairs,
	input  ssd_pkg::qstat_t qstat,
	output logic           push,
	output ssd_pkg::work_t work
);

	localparam int HW = ssd_pkg::DOT_W / 2;

	typedef logic signed [2*HW+1:0] pp_t;

	typedef struct packed {
		pp_t hh;
		pp_t hl;
		pp_t lh;
		pp_t ll;
	} mparts_t;

	// dot-by-dot product as four half-width partial products
	function automatic mparts_t mul_parts(ssd_pkg::dot_t x, ssd_pkg::dot_t y);
		mparts_t              p;
		logic signed [HW-1:0] xh, yh;
		logic signed [HW:0]   xl, yl;
		xh   = x[ssd_pkg::DOT_W-1:HW];
		yh   = y[ssd_pkg::DOT_W-1:HW];
		xl   = {1'b0, x[HW-1:0]};
		yl   = {1'b0, y[HW-1:0]};
		p.hh = xh * yh;
		p.hl = xh * yl;
		p.lh = xl * yh;
		p.ll = xl * yl;
		return p;
	endfunction

	function automatic ssd_pkg::wide_t mul_join(mparts_t p);
		return (ssd_pkg::wide_t'(p.hh) <<< (2 * HW))
			+ ((ssd_pkg::wide_t'(p.hl) + ssd_pkg::wide_t'(p.lh)) <<< HW)
			+ ssd_pkg::wide_t'(p.ll);
	endfunction

	logic en;
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7;

	ssd_pkg::coord_t p0 [3];
	ssd_pkg::coord_t p1 [3];
	ssd_pkg::coord_t q0 [3];
	ssd_pkg::coord_t q1 [3];

	ssd_pkg::geo_t geo_s1, geo_s2, geo_s3, geo_s4, geo_s5, geo_s6;
	ssd_pkg::prod_t aa_s2 [3];
	ssd_pkg::prod_t bb_s2 [3];
	ssd_pkg::prod_t cc_s2 [3];
	ssd_pkg::prod_t dd_s2 [3];
	ssd_pkg::prod_t ee_s2 [3];
	ssd_pkg::dot_t a_s3, b_s3, c_s3, d_s3, e_s3;
	mparts_t ac_s4, bb_s4, be_s4, cd_s4, ae_s4, bd_s4;
	ssd_pkg::dot_t a_s4, c_s4, e_s4, nd_s4, bmd_s4, bpe_s4;
	ssd_pkg::wide_t ac_s5, bb_s5, be_s5, cd_s5, ae_s5, bd_s5;
	ssd_pkg::dot_t a_s5, c_s5, e_s5, nd_s5, bmd_s5, bpe_s5;
	ssd_pkg::wide_t det_s6, sn_s6, tn_s6;
	ssd_pkg::dot_t a_s6, c_s6, e_s6, nd_s6, bmd_s6, bpe_s6;
	logic nd_le0_s6, nd_ge_a_s6, bmd_le0_s6, bmd_ge_a_s6;
	logic e_le0_s6, e_lt_c_s6, bpe_le0_s6, bpe_lt_c_s6;
	ssd_pkg::work_t work_s7;

	ssd_pkg::pjob_t s_job, t_job, j_nd, j_bmd, j_zero, j_one;
	logic det_pos, sn_le0, sn_ge_det, tn_le0, tn_ge_det;

	assign p0[0] = pairs.first_start_x;
	assign p0[1] = pairs.first_start_y;
	assign p0[2] = pairs.first_start_z;
	assign p1[0] = pairs.first_end_x;
	assign p1[1] = pairs.first_end_y;
	assign p1[2] = pairs.first_end_z;
	assign q0[0] = pairs.second_start_x;
	assign q0[1] = pairs.second_start_y;
	assign q0[2] = pairs.second_start_z;
	assign q1[0] = pairs.second_end_x;
	assign q1[1] = pairs.second_end_y;
	assign q1[2] = pairs.second_end_z;

	// whole front moves together; it only stalls when the queue is full
	assign en          = !v_s7 || !qstat.full;
	assign push        = v_s7 && !qstat.full;
	assign pairs.ready = en;
	assign work        = work_s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
		end else if (en) begin
			v_s1 <= pairs.valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 3; k++) begin
				geo_s1.d1[k] <= ssd_pkg::sub_coord(p1[k], p0[k]);
				geo_s1.d2[k] <= ssd_pkg::sub_coord(q1[k], q0[k]);
				geo_s1.r0[k] <= ssd_pkg::sub_coord(p0[k], q0[k]);

				aa_s2[k] <= $signed(geo_s1.d1[k]) * $signed(geo_s1.d1[k]);
				bb_s2[k] <= $signed(geo_s1.d1[k]) * $signed(geo_s1.d2[k]);
				cc_s2[k] <= $signed(geo_s1.d2[k]) * $signed(geo_s1.d2[k]);
				dd_s2[k] <= $signed(geo_s1.d1[k]) * $signed(geo_s1.r0[k]);
				ee_s2[k] <= $signed(geo_s1.d2[k]) * $signed(geo_s1.r0[k]);
			end
			geo_s2 <= geo_s1;

			a_s3 <= ssd_pkg::dot_t'(aa_s2[0]) + ssd_pkg::dot_t'(aa_s2[1])
				+ ssd_pkg::dot_t'(aa_s2[2]);
			b_s3 <= ssd_pkg::dot_t'(bb_s2[0]) + ssd_pkg::dot_t'(bb_s2[1])
				+ ssd_pkg::dot_t'(bb_s2[2]);
			c_s3 <= ssd_pkg::dot_t'(cc_s2[0]) + ssd_pkg::dot_t'(cc_s2[1])
				+ ssd_pkg::dot_t'(cc_s2[2]);
			d_s3 <= ssd_pkg::dot_t'(dd_s2[0]) + ssd_pkg::dot_t'(dd_s2[1])
				+ ssd_pkg::dot_t'(dd_s2[2]);
			e_s3 <= ssd_pkg::dot_t'(ee_s2[0]) + ssd_pkg::dot_t'(ee_s2[1])
				+ ssd_pkg::dot_t'(ee_s2[2]);
			geo_s3 <= geo_s2;

			ac_s4  <= mul_parts(a_s3, c_s3);
			bb_s4  <= mul_parts(b_s3, b_s3);
			be_s4  <= mul_parts(b_s3, e_s3);
			cd_s4  <= mul_parts(c_s3, d_s3);
			ae_s4  <= mul_parts(a_s3, e_s3);
			bd_s4  <= mul_parts(b_s3, d_s3);
			nd_s4  <= -d_s3;
			bmd_s4 <= b_s3 - d_s3;
			bpe_s4 <= b_s3 + e_s3;
			a_s4   <= a_s3;
			c_s4   <= c_s3;
			e_s4   <= e_s3;
			geo_s4 <= geo_s3;

			ac_s5  <= mul_join(ac_s4);
			bb_s5  <= mul_join(bb_s4);
			be_s5  <= mul_join(be_s4);
			cd_s5  <= mul_join(cd_s4);
			ae_s5  <= mul_join(ae_s4);
			bd_s5  <= mul_join(bd_s4);
			a_s5   <= a_s4;
			c_s5   <= c_s4;
			e_s5   <= e_s4;
			nd_s5  <= nd_s4;
			bmd_s5 <= bmd_s4;
			bpe_s5 <= bpe_s4;
			geo_s5 <= geo_s4;

			det_s6      <= ac_s5 - bb_s5;
			sn_s6       <= be_s5 - cd_s5;
			tn_s6       <= ae_s5 - bd_s5;
			nd_le0_s6   <= nd_s5 <= ssd_pkg::DOT_ZERO;
			nd_ge_a_s6  <= nd_s5 >= a_s5;
			bmd_le0_s6  <= bmd_s5 <= ssd_pkg::DOT_ZERO;
			bmd_ge_a_s6 <= bmd_s5 >= a_s5;
			e_le0_s6    <= e_s5 <= ssd_pkg::DOT_ZERO;
			e_lt_c_s6   <= e_s5 < c_s5;
			bpe_le0_s6  <= bpe_s5 <= ssd_pkg::DOT_ZERO;
			bpe_lt_c_s6 <= bpe_s5 < c_s5;
			a_s6        <= a_s5;
			c_s6        <= c_s5;
			e_s6        <= e_s5;
			nd_s6       <= nd_s5;
			bmd_s6      <= bmd_s5;
			bpe_s6      <= bpe_s5;
			geo_s6      <= geo_s5;

			work_s7.s_job <= s_job;
			work_s7.t_job <= t_job;
			work_s7.geo   <= geo_s6;
		end
	end

	// region of the parameter square
	always_comb begin
		det_pos   = det_s6 > ssd_pkg::WIDE_ZERO;
		sn_le0    = sn_s6 <= ssd_pkg::WIDE_ZERO;
		sn_ge_det = sn_s6 >= det_s6;
		tn_le0    = tn_s6 <= ssd_pkg::WIDE_ZERO;
		tn_ge_det = tn_s6 >= det_s6;
		j_zero    = ssd_pkg::mk_job(ssd_pkg::PM_ZERO, ssd_pkg::WIDE_ZERO, ssd_pkg::WIDE_ZERO);
		j_one     = ssd_pkg::mk_job(ssd_pkg::PM_ONE, ssd_pkg::WIDE_ZERO, ssd_pkg::WIDE_ZERO);
		j_nd      = ssd_pkg::clamp_job(nd_le0_s6, nd_ge_a_s6, nd_s6, a_s6);
		j_bmd     = ssd_pkg::clamp_job(bmd_le0_s6, bmd_ge_a_s6, bmd_s6, a_s6);
		s_job     = j_nd;
		t_job     = j_zero;
		if (det_pos) begin
			if (sn_le0) begin
				if (e_le0_s6) begin
					s_job = j_nd;
					t_job = j_zero;
				end else if (e_lt_c_s6) begin
					s_job = j_zero;
					t_job = ssd_pkg::mk_job(ssd_pkg::PM_DIV,
						ssd_pkg::wide_t'(e_s6), ssd_pkg::wide_t'(c_s6));
				end else begin
					s_job = j_bmd;
					t_job = j_one;
				end
			end else if (sn_ge_det) begin
				if (bpe_le0_s6) begin
					s_job = j_nd;
					t_job = j_zero;
				end else if (bpe_lt_c_s6) begin
					s_job = j_one;
					t_job = ssd_pkg::mk_job(ssd_pkg::PM_DIV,
						ssd_pkg::wide_t'(bpe_s6), ssd_pkg::wide_t'(c_s6));
				end else begin
					s_job = j_bmd;
					t_job = j_one;
				end
			end else begin
				if (tn_le0) begin
					s_job = j_nd;
					t_job = j_zero;
				end else if (tn_ge_det) begin
					s_job = j_bmd;
					t_job = j_one;
				end else begin
					s_job = ssd_pkg::mk_job(ssd_pkg::PM_DIV, sn_s6, det_s6);
					t_job = ssd_pkg::mk_job(ssd_pkg::PM_DIV, tn_s6, det_s6);
				end
			end
		end else begin
			// parallel or degenerate
			if (e_le0_s6) begin
				s_job = j_nd;
				t_job = j_zero;
			end else if (!e_lt_c_s6) begin
				s_job = j_bmd;
				t_job = j_one;
			end else begin
				s_job = j_zero;
				t_job = ssd_pkg::mk_job(ssd_pkg::PM_DIV,
					ssd_pkg::wide_t'(e_s6), ssd_pkg::wide_t'(c_s6));
			end
		end
	end

endmodule

@@ sv/ssd_queue.sv @@
// Short FIFO between the front end and the back end.
// Depth is a power of two from ssd_pkg; head is read without latency.
`timescale 1ns / 1ps

module ssd_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  ssd_pkg::work_t  wdata,
	input  logic            pop,
	output ssd_pkg::work_t  head,
	output ssd_pkg::qstat_t qstat
);

	localparam int PW = ssd_pkg::QPTR_W;

	ssd_pkg::work_t  slot_q [ssd_pkg::QUEUE_DEPTH];
	logic [PW-1:0]   wr_ptr_q, rd_ptr_q;
	logic [PW:0]     count_q;

	assign head        = slot_q[rd_ptr_q];
	assign qstat.full  = count_q == (PW + 1)'(ssd_pkg::QUEUE_DEPTH);
	assign qstat.empty = count_q == '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= wdata;
		end
	end

endmodule

@@ sv/ssd_back.sv @@
// Back end: pipelined parameter dividers, closest-point difference,
// squared distance and a pipelined square root. Depends on ssd_pkg.
`timescale 1ns / 1ps

module ssd_back (
	input  logic            clk,
	input  logic            arst_n,
	input  ssd_pkg::work_t  head,
	input  ssd_pkg::qstat_t qstat,
	output logic            pop,
	ssd_out_if.source       result
);

	localparam int NDIV   = ssd_pkg::DIV_STEPS;
	localparam int NROOT  = ssd_pkg::ROOT_W;
	localparam int W      = ssd_pkg::WIDE_W;
	localparam int PW     = ssd_pkg::PARAM_W;
	localparam int SQ_W   = ssd_pkg::SQ_W;
	localparam int ROOT_W = ssd_pkg::ROOT_W;
	localparam int REM_W  = ssd_pkg::REM_W;
	localparam int RND_W  = ssd_pkg::RND_W;
	localparam int SH     = ssd_pkg::DF_W / 2;

	typedef logic signed [2*SH+3:0] spp_t;
	typedef logic signed [SQ_W-1:0] sqs_t;

	typedef struct packed {
		ssd_pkg::pmode_t mode;
		logic [W-1:0]    rem;
		logic [W-1:0]    den;
		ssd_pkg::param_t q;
	} dlane_t;

	typedef struct packed {
		dlane_t        s;
		dlane_t        t;
		ssd_pkg::geo_t geo;
	} drow_t;

	typedef struct packed {
		logic [SQ_W-1:0]   rad;
		logic [REM_W-1:0]  rem;
		logic [ROOT_W-1:0] root;
		ssd_pkg::param_t   s;
		ssd_pkg::param_t   t;
	} rrow_t;

	function automatic dlane_t div_step(dlane_t x);
		dlane_t       y;
		logic [W-1:0] r2;
		y  = x;
		r2 = {x.rem[W-2:0], 1'b0};
		if (r2 >= x.den) begin
			y.rem = r2 - x.den;
			y.q   = {x.q[PW-2:0], 1'b1};
		end else begin
			y.rem = r2;
			y.q   = {x.q[PW-2:0], 1'b0};
		end
		return y;
	endfunction

	// round half up of the extra quotient bit, or a forced end value
	function automatic ssd_pkg::param_t finish(dlane_t x);
		logic [PW:0] sum;
		sum = {1'b0, x.q} + 1'b1;
		unique case (x.mode)
			ssd_pkg::PM_ZERO: return '0;
			ssd_pkg::PM_ONE:  return ssd_pkg::PARAM_ONE;
			default:          return sum[PW:1];
		endcase
	endfunction

	function automatic rrow_t root_step(rrow_t x);
		rrow_t            y;
		logic [REM_W-1:0] rem2;
		logic [REM_W-1:0] trial;
		y     = x;
		rem2  = {x.rem[REM_W-3:0], x.rad[SQ_W-1 -: 2]};
		trial = {{(REM_W - ROOT_W - 2){1'b0}}, x.root, 2'b01};
		y.rad = {x.rad[SQ_W-3:0], 2'b00};
		if (rem2 >= trial) begin
			y.rem  = rem2 - trial;
			y.root = {x.root[ROOT_W-2:0], 1'b1};
		end else begin
			y.rem  = rem2;
			y.root = {x.root[ROOT_W-2:0], 1'b0};
		end
		return y;
	endfunction

	logic  en;
	drow_t div_in;
	drow_t div_s [NDIV];
	logic  dv_s  [NDIV];

	logic            v_s18, v_s19, v_s20, v_s21, v_s22, v_s23;
	ssd_pkg::param_t s_s18, t_s18, s_s19, t_s19, s_s20, t_s20, s_s21, t_s21;
	ssd_pkg::param_t s_s22, t_s22, s_s23, t_s23;
	ssd_pkg::geo_t   geo_s18;
	ssd_pkg::df_t    r0sh_s19 [3];
	ssd_pkg::df_t    sd_s19   [3];
	ssd_pkg::df_t    td_s19   [3];
	ssd_pkg::df_t    df_s20   [3];
	spp_t            sqh_s21  [3];
	spp_t            sqm_s21  [3];
	spp_t            sql_s21  [3];
	logic [SQ_W-1:0] sq_s22   [3];
	logic [SQ_W-1:0] rad_s23;

	rrow_t root_in;
	rrow_t rt_s [NROOT];
	logic  rv_s [NROOT];

	logic [RND_W-1:0] shifted;
	logic [RND_W:0]   rsum;
	logic [RND_W-1:0] half;
	ssd_pkg::dist_t   dist_c;

	logic            out_v_q;
	ssd_pkg::dist_t  dist_q;
	ssd_pkg::param_t s_q, t_q;

	assign en  = !out_v_q || result.ready;
	assign pop = en && !qstat.empty;

	always_comb begin
		div_in.s.mode = head.s_job.mode;
		div_in.s.rem  = head.s_job.num;
		div_in.s.den  = head.s_job.den;
		div_in.s.q    = '0;
		div_in.t.mode = head.t_job.mode;
		div_in.t.rem  = head.t_job.num;
		div_in.t.den  = head.t_job.den;
		div_in.t.q    = '0;
		div_in.geo    = head.geo;
	end

	// one quotient bit per stage for both parameters
	for (genvar i = 0; i < NDIV; i++) begin : g_div
		if (i == 0) begin : g_first
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					dv_s[i] <= 1'b0;
				end else if (en) begin
					dv_s[i] <= !qstat.empty;
				end
			end
			always_ff @(posedge clk) begin
				if (en) begin
					div_s[i].s   <= div_step(div_in.s);
					div_s[i].t   <= div_step(div_in.t);
					div_s[i].geo <= div_in.geo;
				end
			end
		end else begin : g_next
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					dv_s[i] <= 1'b0;
				end else if (en) begin
					dv_s[i] <= dv_s[i-1];
				end
			end
			always_ff @(posedge clk) begin
				if (en) begin
					div_s[i].s   <= div_step(div_s[i-1].s);
					div_s[i].t   <= div_step(div_s[i-1].t);
					div_s[i].geo <= div_s[i-1].geo;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s18 <= 1'b0;
			v_s19 <= 1'b0;
			v_s20 <= 1'b0;
			v_s21 <= 1'b0;
			v_s22 <= 1'b0;
			v_s23 <= 1'b0;
		end else if (en) begin
			v_s18 <= dv_s[NDIV-1];
			v_s19 <= v_s18;
			v_s20 <= v_s19;
			v_s21 <= v_s20;
			v_s22 <= v_s21;
			v_s23 <= v_s22;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			s_s18   <= finish(div_s[NDIV-1].s);
			t_s18   <= finish(div_s[NDIV-1].t);
			geo_s18 <= div_s[NDIV-1].geo;

			for (int k = 0; k < 3; k++) begin
				r0sh_s19[k] <= ssd_pkg::df_t'($signed(geo_s18.r0[k])) <<< ssd_pkg::PARAM_FRAC;
				sd_s19[k]   <= $signed({1'b0, s_s18}) * $signed(geo_s18.d1[k]);
				td_s19[k]   <= $signed({1'b0, t_s18}) * $signed(geo_s18.d2[k]);
				df_s20[k]   <= r0sh_s19[k] + sd_s19[k] - td_s19[k];
				// square from half-width partial products
				sqh_s21[k]  <= $signed(df_s20[k][ssd_pkg::DF_W-1:SH])
					* $signed(df_s20[k][ssd_pkg::DF_W-1:SH]);
				sqm_s21[k]  <= $signed(df_s20[k][ssd_pkg::DF_W-1:SH])
					* $signed({1'b0, df_s20[k][SH-1:0]});
				sql_s21[k]  <= $signed({1'b0, df_s20[k][SH-1:0]})
					* $signed({1'b0, df_s20[k][SH-1:0]});
				sq_s22[k]   <= (sqs_t'(sqh_s21[k]) <<< (2 * SH))
					+ (sqs_t'(sqm_s21[k]) <<< (SH + 1)) + sqs_t'(sql_s21[k]);
			end
			s_s19 <= s_s18;
			t_s19 <= t_s18;
			s_s20 <= s_s19;
			t_s20 <= t_s19;
			s_s21 <= s_s20;
			t_s21 <= t_s20;
			s_s22 <= s_s21;
			t_s22 <= t_s21;

			// four times the squared distance: one extra root bit for rounding
			rad_s23 <= (sq_s22[0] + sq_s22[1] + sq_s22[2]) << 2;
			s_s23   <= s_s22;
			t_s23   <= t_s22;
		end
	end

	always_comb begin
		root_in.rad  = rad_s23;
		root_in.rem  = '0;
		root_in.root = '0;
		root_in.s    = s_s23;
		root_in.t    = t_s23;
	end

	// one root bit per stage
	for (genvar i = 0; i < NROOT; i++) begin : g_root
		if (i == 0) begin : g_first
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					rv_s[i] <= 1'b0;
				end else if (en) begin
					rv_s[i] <= v_s23;
				end
			end
			always_ff @(posedge clk) begin
				if (en) begin
					rt_s[i] <= root_step(root_in);
				end
			end
		end else begin : g_next
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					rv_s[i] <= 1'b0;
				end else if (en) begin
					rv_s[i] <= rv_s[i-1];
				end
			end
			always_ff @(posedge clk) begin
				if (en) begin
					rt_s[i] <= root_step(rt_s[i-1]);
				end
			end
		end
	end

	always_comb begin
		shifted = rt_s[NROOT-1].root[ROOT_W-1:ssd_pkg::DIST_SHIFT];
		rsum    = {1'b0, shifted} + 1'b1;
		half    = rsum[RND_W:1];
		if (half > RND_W'(ssd_pkg::DIST_MAX)) begin
			dist_c = ssd_pkg::DIST_MAX;
		end else begin
			dist_c = half[ssd_pkg::DIST_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (en) begin
			out_v_q <= rv_s[NROOT-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dist_q <= dist_c;
			s_q    <= rt_s[NROOT-1].s;
			t_q    <= rt_s[NROOT-1].t;
		end
	end

	assign result.valid        = out_v_q;
	assign result.distance     = dist_q;
	assign result.param_first  = s_q;
	assign result.param_second = t_q;

endmodule

@@ sv/segment_segment_distance_3d_unit.sv @@
// Shortest distance between two 3D segments, with closest-point parameters.
// Throughput one request per cycle when the result side does not stall, set by
// the fully pipelined dividers and square root. A 4-entry queue decouples
// front and back; the front keeps taking requests while a result waits, until
// the queue is full. arst_n clears all valid flags and queue pointers.
`timescale 1ns / 1ps
`include "segment_segment_distance_3d_unit_assert.svh"

module segment_segment_distance_3d_unit (
	input  logic      clk,
	input  logic      arst_n,
	ssd_in_if.sink    pairs,
	ssd_out_if.source result
);

	ssd_pkg::work_t  work;
	ssd_pkg::work_t  head;
	ssd_pkg::qstat_t qstat;
	logic            push;
	logic            pop;
	logic            params_ok;

	ssd_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.pairs  (pairs),
		.qstat  (qstat),
		.push   (push),
		.work   (work)
	);

	ssd_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (work),
		.pop    (pop),
		.head   (head),
		.qstat  (qstat)
	);

	ssd_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.head   (head),
		.qstat  (qstat),
		.pop    (pop),
		.result (result)
	);

	assign params_ok = (result.param_first <= ssd_pkg::PARAM_ONE)
		&& (result.param_second <= ssd_pkg::PARAM_ONE);

	`SSD_ASSERT_NEVER(a_queue_full_and_empty, qstat.full && qstat.empty)
	`SSD_ASSERT_IMPLY(a_no_push_when_full, qstat.full && !pop, !push || !qstat.full)
	`SSD_ASSERT_IMPLY(a_param_range, result.valid, params_ok)
	`SSD_ASSERT_IMPLY(a_pop_needs_data, pop, !qstat.empty)

endmodule
